### rtl/first_fit_track_assigner_top_macros.svh
// ----------------------------------------------------------------------------
// first_fit_track_assigner_top_macros.svh
// Assertion macros shared by the track assigner checkers.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_TRACK_ASSIGNER_TOP_MACROS_SVH
`define FIRST_FIT_TRACK_ASSIGNER_TOP_MACROS_SVH

// Property checked only outside reset.
`define FFTA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FFTA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ffta_pkg.sv
// ----------------------------------------------------------------------------
// ffta_pkg
// Types, sizes and command/status bundles of the first-fit track assigner.
// ----------------------------------------------------------------------------
package ffta_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int TIME_BITS  = 32;

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);

  localparam logic       FUNC_PLACE = 1'b0;
  localparam logic       FUNC_CLEAR = 1'b1;
  localparam logic [7:0] PAUSE_PITCH = 8'hFF;  // -1

  typedef struct packed {
    logic               func;
    logic signed [31:0] start_time;
    logic signed [31:0] duration;
    logic [6:0]         pitch;
    logic [6:0]         velocity;
    logic               is_named;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        track_index;
    logic              is_pause;
    logic [31:0]       word_length;
    logic signed [7:0] word_pitch;
    logic [6:0]        word_velocity;
    logic              opened_track;
    logic              overflow;
    logic [4:0]        open_tracks;
    logic              last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLACE,
    ST_NOTE
  } ffta_state_e;

  typedef struct packed {
    logic accept;  // request taken this cycle
    logic place;   // update tracks, load first word
    logic note;    // load trailing note word
  } ffta_cmd_t;

  typedef struct packed {
    logic in_place;   // incoming request is a valid note
    logic two_words;  // placement needs a pause word first
    logic out_free;   // output register can take a word
  } ffta_status_t;

endpackage

### rtl/ffta_ctrl.sv
// ----------------------------------------------------------------------------
// ffta_ctrl
// Sequencer: accept, place, optional trailing note word.
// ----------------------------------------------------------------------------
module ffta_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ffta_pkg::ffta_status_t status_i,
  output ffta_pkg::ffta_cmd_t    cmd_o
);
  import ffta_pkg::*;

  ffta_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.in_place) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        if (status_i.out_free) state_d = status_i.two_words ? ST_NOTE : ST_IDLE;
      end
      ST_NOTE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_PLACE: cmd_o.place = status_i.out_free;
      ST_NOTE:  cmd_o.note  = status_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/ffta_datapath.sv
// ----------------------------------------------------------------------------
// ffta_datapath
// Track end table, parallel fit compare, placement and output register.
// ----------------------------------------------------------------------------
module ffta_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ffta_pkg::in_item_t     in_item_i,
  input  ffta_pkg::ffta_cmd_t    cmd_i,
  output ffta_pkg::ffta_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ffta_pkg::out_item_t    out_item_o
);
  import ffta_pkg::*;

  function automatic logic [IDX_W-1:0] first_hit(input logic [MAX_TRACKS-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  logic [TIME_BITS-1:0]  end_q [MAX_TRACKS];
  logic [CNT_W-1:0]      count_q;
  logic [MAX_TRACKS-1:0] hit_q, hit_d;
  logic [TIME_BITS-1:0]  begin_q, begin_d;
  logic [TIME_BITS-1:0]  dur_q, dur_d;
  logic [TIME_BITS-1:0]  stop_q, stop_d;
  logic [6:0]            pitch_q, vel_q;
  logic [IDX_W-1:0]      found_q;
  logic                  opened_q;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  // placement, valid in the place cycle
  logic                  any_hit, full, opened, ovf;
  logic [IDX_W-1:0]      found;
  logic [TIME_BITS-1:0]  base, gap;
  logic [CNT_W-1:0]      count_new;
  logic                  load;

  assign begin_d = TIME_BITS'($unsigned(in_item_i.start_time));
  assign dur_d   = TIME_BITS'($unsigned(in_item_i.duration));
  assign stop_d  = begin_d + dur_d;

  always_comb begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      hit_d[i] = (CNT_W'(i) < count_q) && (end_q[i] <= begin_d);
    end
  end

  assign status_o.in_place = (in_item_i.func == FUNC_PLACE) && in_item_i.is_named &&
                             !in_item_i.start_time[31] && !in_item_i.duration[31] &&
                             (in_item_i.duration != '0);

  assign any_hit   = |hit_q;
  assign full      = (count_q >= CNT_W'(MAX_TRACKS));
  assign opened    = !any_hit && !full;
  assign ovf       = !any_hit && full;
  assign found     = any_hit ? first_hit(hit_q) : IDX_W'(count_q);
  assign base      = opened ? '0 : end_q[found];
  assign gap       = begin_q - base;
  assign count_new = opened ? count_q + CNT_W'(1) : count_q;

  assign status_o.two_words = !ovf && (gap != '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign load = cmd_i.place || cmd_i.note;

  always_comb begin
    out_d = '0;
    if (cmd_i.note) begin
      out_d.track_index   = 4'(found_q);
      out_d.word_length   = 32'(dur_q);
      out_d.word_pitch    = {1'b0, pitch_q};
      out_d.word_velocity = vel_q;
      out_d.opened_track  = opened_q;
      out_d.open_tracks   = 5'(count_q);
      out_d.last_word     = 1'b1;
    end else if (ovf) begin
      out_d.overflow    = 1'b1;
      out_d.open_tracks = 5'(count_q);
      out_d.last_word   = 1'b1;
    end else begin
      out_d.track_index  = 4'(found);
      out_d.opened_track = opened;
      out_d.open_tracks  = 5'(count_new);
      if (gap != '0) begin
        out_d.is_pause    = 1'b1;
        out_d.word_length = 32'(gap);
        out_d.word_pitch  = PAUSE_PITCH;
      end else begin
        out_d.word_length   = 32'(dur_q);
        out_d.word_pitch    = {1'b0, pitch_q};
        out_d.word_velocity = vel_q;
        out_d.last_word     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && (in_item_i.func == FUNC_CLEAR)) begin
        count_q <= '0;
      end else if (cmd_i.place) begin
        count_q <= count_new;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hit_q   <= hit_d;
      begin_q <= begin_d;
      dur_q   <= dur_d;
      stop_q  <= stop_d;
      pitch_q <= in_item_i.pitch;
      vel_q   <= in_item_i.velocity;
    end
    if (cmd_i.place) begin
      found_q  <= found;
      opened_q <= opened;
      if (!ovf) end_q[found] <= stop_q;
    end
    if (load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/first_fit_track_assigner_top.sv
// ----------------------------------------------------------------------------
// first_fit_track_assigner_top
// First-fit placement of time-sorted notes onto tracks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one request: place a
//   note (func = 0) or clear all tracks (func = 1). Output channel
//   (out_valid_o/out_ready_i/out_item_o) returns the words of a placed note:
//   an optional pause word, then the note word flagged last_word.
//   Clear requests and rejected notes (unnamed, negative start, duration <= 0)
//   are taken in the idle state and return nothing.
//   A placed note passes through accept (all track ends compared in parallel),
//   then place, then a note step when a pause word precedes the note word; the
//   track end table has one write port, updated in the place cycle.
//   The place step loads the first word once the output register is free.
//   When every track is busy and none fits, a single overflow word returns.
//   A registered output holds each word while out_ready_i is low; placement
//   waits until that register is free, and in_ready_o stays low meanwhile.
//   Reset empties all tracks and drops any pending word; track end values
//   are not reset and are only read for open tracks.
// ----------------------------------------------------------------------------
module first_fit_track_assigner_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffta_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffta_pkg::out_item_t out_item_o
);
  import ffta_pkg::*;

  ffta_cmd_t    cmd;
  ffta_status_t status;

  ffta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ffta_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/ffta_checker.sv
// ----------------------------------------------------------------------------
// ffta_checker
// Port-level checks of the track assigner, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_track_assigner_top_macros.svh"

module ffta_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ffta_pkg::out_item_t out_item_o
);
  import ffta_pkg::*;

  // stalled word must hold
  `FFTA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "output word changed while stalled")

  // only a pause word is ever followed by another word of the same request
  `FFTA_ASSERT(a_pause_shape, clk_i, rst_ni, out_valid_o && !out_item_o.last_word |-> out_item_o.is_pause && !out_item_o.overflow && (out_item_o.word_pitch == PAUSE_PITCH) && (out_item_o.word_length != '0), "non-final word is not a pause")

  // overflow only with all tracks open
  `FFTA_ASSERT(a_overflow_full, clk_i, rst_ni, out_valid_o && out_item_o.overflow |-> out_item_o.last_word && (out_item_o.open_tracks == 5'(MAX_TRACKS)) && !out_item_o.opened_track, "overflow word malformed")

  // the trailing note word is still owed: no new request may enter
  `FFTA_ASSERT(a_pause_blocks_input, clk_i, rst_ni, out_valid_o && !out_item_o.last_word |-> !in_ready_o, "request taken while a note word is owed")

  `FFTA_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind first_fit_track_assigner_top ffta_checker u_ffta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### verif/tb_first_fit_track_assigner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_track_assigner_top
// Self-checking bench for the first-fit track assigner.
// A directed table covers clear, rejected notes, value extremes and a full
// track set. Random note streams follow. Each request is scored by a
// first-fit model of the track ends (typed table rows by their listed words),
// and the words that come back are compared field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_first_fit_track_assigner_top;
  import ffta_pkg::*;

  localparam int          REQ_TARGET  = 1300;
  localparam int          N_DIRECTED  = MAX_TRACKS + 9;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int          MAX_PRINTS  = 100;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } words_t;

  typedef struct {
    in_item_t req;
    bit       typed;
    words_t   want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // first-fit model state
  logic [31:0] end_tick [MAX_TRACKS];
  int          tracks_open;

  out_item_t words_due [$];
  int        errors;
  int        requests;
  int        notes_placed;
  int        overflows;
  int        words_seen;
  bit        calm;
  bit        hold_off_req;
  int        burst_left;

  first_fit_track_assigner_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%h want 0x%h", name, got, want));
  endtask

  function automatic out_item_t make_word(logic [3:0] trk, logic pause, logic [31:0] len,
                                          logic [7:0] tone, logic [6:0] vol,
                                          logic opened, logic ovf,
                                          logic [4:0] open_cnt, logic last);
    out_item_t w;
    w.track_index   = trk;
    w.is_pause      = pause;
    w.word_length   = len;
    w.word_pitch    = tone;
    w.word_velocity = vol;
    w.opened_track  = opened;
    w.overflow      = ovf;
    w.open_tracks   = open_cnt;
    w.last_word     = last;
    return w;
  endfunction

  function automatic in_item_t note_req(logic [31:0] start, logic [31:0] len,
                                        logic [6:0] tone, logic [6:0] vol, logic named);
    in_item_t r;
    r.func       = FUNC_PLACE;
    r.start_time = start;
    r.duration   = len;
    r.pitch      = tone;
    r.velocity   = vol;
    r.is_named   = named;
    return r;
  endfunction

  // First-fit placement: returns the words this request produces.
  function automatic words_t place_note(input in_item_t req);
    words_t      res;
    out_item_t   w;
    logic [31:0] onset;
    logic [31:0] gap;
    int          hit;
    int          t;
    logic        opened;
    res    = '0;
    w      = '0;
    hit    = -1;
    opened = 1'b0;
    if (req.func == FUNC_CLEAR) begin
      tracks_open = 0;
      return res;
    end
    if (!req.is_named || req.start_time[31] || req.duration[31] || req.duration == 0)
      return res;
    onset = req.start_time;
    for (t = 0; t < tracks_open; t++) begin
      if (end_tick[t] <= onset) begin
        hit = t;
        break;
      end
    end
    if (hit < 0) begin
      if (tracks_open >= MAX_TRACKS) begin
        w.overflow    = 1'b1;
        w.open_tracks = 5'(tracks_open);
        w.last_word   = 1'b1;
        res.count     = 2'd1;
        res.first     = w;
        return res;
      end
      hit           = tracks_open;
      end_tick[hit] = '0;
      tracks_open++;
      opened = 1'b1;
    end
    gap           = onset - end_tick[hit];
    end_tick[hit] = onset + req.duration;
    w.track_index  = 4'(hit);
    w.opened_track = opened;
    w.open_tracks  = 5'(tracks_open);
    if (gap != 0) begin
      w.is_pause      = 1'b1;
      w.word_length   = gap;
      w.word_pitch    = PAUSE_PITCH;
      w.word_velocity = '0;
      w.last_word     = 1'b0;
      res.first       = w;
      res.count       = 2'd1;
    end
    w.is_pause      = 1'b0;
    w.word_length   = req.duration;
    w.word_pitch    = {1'b0, req.pitch};
    w.word_velocity = req.velocity;
    w.last_word     = 1'b1;
    if (res.count == 0) res.first = w;
    else res.second = w;
    res.count = res.count + 2'd1;
    return res;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Drive one request, wait for it to be taken, then queue its words.
  task automatic offer(input in_item_t req, input bit typed, input words_t typed_words);
    words_t      due;
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    due = place_note(req);
    if (typed) due = typed_words;
    requests++;
    if (due.count != 0) notes_placed++;
    if (due.count != 0 && due.first.overflow) overflows++;
    if (due.count >= 1) words_due.insert(words_due.size(), due.first);
    if (due.count == 2) words_due.insert(words_due.size(), due.second);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  always @(posedge clk) begin : word_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (words_due.size() == 0) begin
        flag_error($sformatf("unexpected word 0x%h", out_item));
      end else begin
        want = words_due.pop_front();
        check_field("track_index", out_item.track_index, want.track_index);
        check_field("is_pause", out_item.is_pause, want.is_pause);
        check_field("word_length", out_item.word_length, want.word_length);
        check_field("word_pitch", out_item.word_pitch, want.word_pitch);
        check_field("word_velocity", out_item.word_velocity, want.word_velocity);
        check_field("opened_track", out_item.opened_track, want.opened_track);
        check_field("overflow", out_item.overflow, want.overflow);
        check_field("open_tracks", out_item.open_tracks, want.open_tracks);
        check_field("last_word", out_item.last_word, want.last_word);
      end
    end
  end

  initial begin : ready_gen
    int unsigned stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_CYCLES;
      end else begin
        stall = idle_len();
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   rows [N_DIRECTED];
    in_item_t    req;
    logic [31:0] cursor;
    logic [31:0] step;
    logic [31:0] len;
    int          i;
    int          k;
    int          seg_len;
    int          density;
    int          kind;
    bit          held;
    bit          drained;

    in_valid     = 1'b0;
    in_item      = '0;
    rst_n        = 1'b0;
    tracks_open  = 0;
    errors       = 0;
    requests     = 0;
    notes_placed = 0;
    overflows    = 0;
    words_seen   = 0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    held         = 1'b0;
    drained      = 1'b0;

    // first note after reset opens track 0 with no pause
    rows[0] = '{req: note_req(32'd0, 32'd5, 7'd127, 7'd127, 1'b1), typed: 1'b1,
                want: '{count: 2'd1,
                        first: make_word(4'd0, 1'b0, 32'd5, 8'd127, 7'd127, 1'b1, 1'b0,
                                         5'd1, 1'b1),
                        second: '0}};
    // rejected: unnamed, negative start, zero and negative durations
    rows[1] = '{req: note_req(32'd3, 32'd4, 7'd1, 7'd1, 1'b0), typed: 1'b1, want: '0};
    rows[2] = '{req: note_req(32'h8000_0000, 32'd10, 7'd2, 7'd2, 1'b1), typed: 1'b1,
                want: '0};
    rows[3] = '{req: note_req(32'd10, 32'd0, 7'd3, 7'd3, 1'b1), typed: 1'b1, want: '0};
    rows[4] = '{req: note_req(32'd10, 32'h8000_0000, 7'd4, 7'd4, 1'b1), typed: 1'b1,
                want: '0};
    // clear with every other field set
    req      = note_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 7'h7F, 1'b1);
    req.func = FUNC_CLEAR;
    rows[5] = '{req: req, typed: 1'b1, want: '0};
    // largest start and duration: pause fills the gap, track end passes 2^31
    rows[6] = '{req: note_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd0, 7'd0, 1'b1), typed: 1'b1,
                want: '{count: 2'd2,
                        first: make_word(4'd0, 1'b1, 32'h7FFF_FFFF, PAUSE_PITCH, 7'd0,
                                         1'b1, 1'b0, 5'd1, 1'b0),
                        second: make_word(4'd0, 1'b0, 32'h7FFF_FFFF, 8'd0, 7'd0,
                                          1'b1, 1'b0, 5'd1, 1'b1)}};
    // earlier starts fill every remaining track
    for (i = 0; i < MAX_TRACKS - 1; i++)
      rows[7 + i] = '{req: note_req(32'd30, 32'd50, 7'(i * 8), 7'(127 - i * 8), 1'b1),
                      typed: 1'b0, want: '0};
    // all tracks busy: overflow word
    rows[MAX_TRACKS + 6] = '{req: note_req(32'd20, 32'd7, 7'd64, 7'd64, 1'b1), typed: 1'b1,
                             want: '{count: 2'd1,
                                     first: make_word(4'd0, 1'b0, 32'd0, 8'd0, 7'd0, 1'b0,
                                                      1'b1, 5'(MAX_TRACKS), 1'b1),
                                     second: '0}};
    rows[MAX_TRACKS + 7] = '{req: note_req(32'd80, 32'd1, 7'd5, 7'd6, 1'b1), typed: 1'b0,
                             want: '0};
    req      = note_req(32'd0, 32'd0, 7'd0, 7'd0, 1'b0);
    req.func = FUNC_CLEAR;
    rows[MAX_TRACKS + 8] = '{req: req, typed: 1'b0, want: '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) offer(rows[i].req, rows[i].typed, rows[i].want);

    // random note streams, one segment at a time
    cursor = '0;
    while (requests < REQ_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        req      = note_req($urandom, $urandom, 7'($urandom), 7'($urandom), 1'($urandom));
        req.func = FUNC_CLEAR;
        offer(req, 1'b0, '0);
      end
      case ($urandom_range(0, 9))
        0:       cursor = $urandom_range(32'h7F00_0000, 32'h7FFF_FFF0);
        1:       cursor = $urandom_range(0, 32'h7FFF_0000);
        default: cursor = $urandom_range(0, 2000);
      endcase
      density = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 48);
      for (k = 0; k < seg_len; k++) begin
        case (density)
          0: begin
            step = $urandom_range(0, 400);
            len  = $urandom_range(1, 300);
          end
          1: begin
            step = $urandom_range(0, 40);
            len  = $urandom_range(1, 400);
          end
          2: begin  // dense: piles up to a full track set
            step = $urandom_range(0, 5);
            len  = $urandom_range(100, 3000);
          end
          default: begin
            step = $urandom_range(0, 1000);
            len  = $urandom_range(1, 32'h7FFF_FFFF);
          end
        endcase
        cursor = cursor + step;
        if (cursor[31]) cursor = $urandom_range(0, 1000);
        req  = note_req(cursor, len, 7'($urandom), 7'($urandom), 1'b1);
        kind = $urandom_range(0, 99);
        if (kind >= 96) begin
          req.func       = 1'($urandom);
          req.start_time = $urandom;
          req.duration   = $urandom;
          req.is_named   = 1'($urandom);
        end else if (kind >= 93) begin
          req.func = FUNC_CLEAR;
        end else if (kind >= 85) begin
          case ($urandom_range(0, 2))
            0:       req.is_named = 1'b0;
            1:       req.start_time = $urandom | 32'h8000_0000;
            default: req.duration = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
          endcase
        end else if (kind >= 80) begin
          // starts up to 50 before the cursor
          req.start_time = cursor - $urandom_range(0, 50);
        end
        offer(req, 1'b0, '0);

        if (!held && notes_placed >= 300) begin
          held         = 1'b1;
          hold_off_req = 1'b1;
          burst_left   = 60;
        end
        if (!drained && notes_placed >= 700) begin
          drained = 1'b1;
          drain();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("tb: %0d requests sent, %0d notes answered, %0d overflow drops",
             requests, notes_placed, overflows);
    $display("tb: %0d words checked, %0d mismatches", words_seen, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### first_fit_track_assigner_top.f
+incdir+rtl
rtl/ffta_pkg.sv
rtl/ffta_ctrl.sv
rtl/ffta_datapath.sv
rtl/first_fit_track_assigner_top.sv
rtl/ffta_checker.sv
verif/tb_first_fit_track_assigner_top.sv
